// ===== hw/rtl/scb_pkg.sv =====
// Shared types, select codes and the color correction function
// for the seam blend compositor. No dependencies.
`default_nettype none
package scb_pkg;

  localparam int GainW   = 10;
  localparam int OffsetW = 11;
  localparam int PixW    = 24;

  localparam logic [1:0] SEL_LEFT  = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_MIX   = 2'd2;

  typedef struct packed {
    logic [1:0] sel;
    logic       is_seam;
    logic       last;
  } ctl_t;

  function automatic logic [7:0] correct_chan(input logic [7:0] p,
                                              input logic [GainW-1:0] g,
                                              input logic [OffsetW-1:0] o);
    logic signed [20:0] v;
    logic [17:0]        prod;
    logic [7:0]         q;
    prod = g * p;
    v = $signed({3'b000, prod}) + $signed({{6{o[OffsetW-1]}}, o, 4'b0000});
    if (v < 0) begin
      q = 8'd0;
    end else if (v[20:8] > 13'd255) begin
      q = 8'd255;
    end else begin
      q = v[15:8];
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scb_geom.sv =====
// Seam and band geometry pipeline: four register stages from the column
// and the registers to the region select, band offset and divisor. Uses scb_pkg.
`default_nettype none
module scb_geom
  import scb_pkg::*;
#(
  parameter int IMAGE_WIDTH = 640,
  parameter int XW = $clog2(IMAGE_WIDTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [10:0]   column,
  input  wire logic [10:0]   shift_dx,
  input  wire logic [15:0]   seam_pos,
  input  wire logic [9:0]    band_req,
  output ctl_t               ctl,
  output logic [XW-1:0]      x,
  output logic [XW-1:0]      d
);
  localparam int GW = $clog2(2 * IMAGE_WIDTH) + 3;
  localparam int LW = $clog2(IMAGE_WIDTH + 1);
  localparam int PW = 16 + LW;
  localparam logic signed [GW-1:0] WS  = GW'(IMAGE_WIDTH);
  localparam logic signed [GW-1:0] WM1 = GW'(IMAGE_WIDTH - 1);
  localparam logic signed [GW-1:0] ONE = GW'(1);
  localparam logic signed [GW-1:0] ZRO = GW'(0);

  logic signed [GW-1:0] dxs, os_c, t_c, oe_c, len_c;
  assign dxs = GW'($signed(shift_dx));

  always_comb begin
    os_c = (dxs < ZRO) ? -dxs : ZRO;
    if (os_c > WS) begin
      os_c = WS;
    end
    t_c = (dxs > ZRO) ? WS - dxs : WS;
    oe_c = (t_c < os_c) ? os_c : t_c;
    len_c = oe_c - os_c;
  end

  logic [10:0]          c1, c2, c3;
  logic signed [GW-1:0] os1;
  logic [LW-1:0]        len1;
  logic [PW-1:0]        prod1;

  always_ff @(posedge clk) begin
    if (en) begin
      c1    <= column;
      os1   <= os_c;
      len1  <= len_c[LW-1:0];
      prod1 <= seam_pos * len_c[LW-1:0];
    end
  end

  logic [PW:0]          rnd;
  logic signed [GW-1:0] s1raw, s1_c, s0raw, s0_c;
  always_comb begin
    rnd   = {1'b0, prod1} + (PW+1)'(32768);
    s1raw = os1 + GW'(rnd[PW:16]);
    s1_c  = (s1raw < ONE) ? ONE : ((s1raw > WM1) ? WM1 : s1raw);
    s0raw = s1_c + dxs;
    s0_c  = (s0raw < ONE) ? ONE : ((s0raw > WM1) ? WM1 : s0raw);
  end

  logic signed [GW-1:0] s1_2, s0_2, s1_3, s0_3, bs3, be3, n3;
  logic                 none2, none3;

  always_ff @(posedge clk) begin
    if (en) begin
      c2    <= c1;
      s1_2  <= s1_c;
      s0_2  <= s0_c;
      none2 <= (len1 == '0);
    end
  end

  logic signed [GW-1:0] h_c, bsr, ber, bs_c, be_c;
  always_comb begin
    h_c  = GW'(band_req[9:1]);
    bsr  = s0_2 - h_c;
    ber  = s0_2 + h_c;
    bs_c = (bsr < ONE) ? ONE : bsr;
    be_c = (ber > WM1) ? WM1 : ber;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3    <= c2;
      s1_3  <= s1_2;
      s0_3  <= s0_2;
      bs3   <= bs_c;
      be3   <= be_c;
      n3    <= be_c - bs_c;
      none3 <= none2;
    end
  end

  logic signed [GW-1:0] cs, b1r, b1, e1r, e1, r1, marker, rowlen, xs, ds;
  logic                 hard;
  ctl_t                 ctl_c;
  always_comb begin
    cs   = GW'(c3);
    hard = (n3 < GW'(4));
    b1r  = bs3 - dxs;
    b1   = (b1r < ZRO) ? ZRO : ((b1r > WM1) ? WM1 : b1r);
    e1r  = be3 - dxs;
    e1   = (e1r < b1 + ONE) ? b1 + ONE : ((e1r > WS) ? WS : e1r);
    r1   = (e1 > WM1) ? WM1 : e1;
    xs   = cs - bs3;
    ds   = n3 - ONE;
    if (none3) begin
      marker    = WS;
      rowlen    = WS + WS;
      ctl_c.sel = (cs < WS) ? SEL_LEFT : SEL_RIGHT;
    end else if (hard) begin
      marker    = s0_3;
      rowlen    = s0_3 + WS - s1_3;
      ctl_c.sel = (cs < s0_3) ? SEL_LEFT : SEL_RIGHT;
    end else begin
      marker    = bs3 + (n3 >>> 1);
      rowlen    = be3 + WS - r1;
      if (cs < bs3) begin
        ctl_c.sel = SEL_LEFT;
      end else if (cs < be3) begin
        ctl_c.sel = SEL_MIX;
      end else begin
        ctl_c.sel = SEL_RIGHT;
      end
    end
    ctl_c.is_seam = (cs == marker);
    ctl_c.last    = (cs == rowlen - ONE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= ctl_c;
      x   <= xs[XW-1:0];
      d   <= ds[XW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/scb_mix.sv =====
// Feather mix: weighted sums per channel, then an eight stage restoring
// divider by the band length minus one, and the final pixel select. Uses scb_pkg.
`default_nettype none
module scb_mix
  import scb_pkg::*;
#(
  parameter int IMAGE_WIDTH = 640,
  parameter int XW = $clog2(IMAGE_WIDTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            valid_in,
  input  wire ctl_t            ctl_in,
  input  wire logic [XW-1:0]   x_in,
  input  wire logic [XW-1:0]   d_in,
  input  wire logic [PixW-1:0] lp_in,
  input  wire logic [PixW-1:0] rp_in,
  output logic                 valid_out,
  output logic [PixW-1:0]      pixel_out,
  output logic                 seam_out,
  output logic                 last_out
);
  localparam int NW = XW + 9;

  logic            v   [0:8];
  ctl_t            ctl [0:8];
  logic [XW-1:0]   dd  [0:8];
  logic [PixW-1:0] pix [0:8];
  logic [NW-1:0]   rem [0:8][0:2];
  logic [7:0]      q   [0:8][0:2];

  logic [XW-1:0] dmx;
  assign dmx = d_in - x_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= ctl_in;
      dd[0]  <= d_in;
      pix[0] <= (ctl_in.sel == SEL_LEFT) ? lp_in : rp_in;
      for (int ch = 0; ch < 3; ch++) begin
        rem[0][ch] <= NW'(dmx * lp_in[8*ch +: 8]) + NW'(x_in * rp_in[8*ch +: 8]);
        q[0][ch]   <= 8'd0;
      end
    end
  end

  for (genvar j = 1; j <= 8; j++) begin : g_div
    logic [NW-1:0] trial;
    assign trial = NW'(dd[j-1]) << (8 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl[j] <= ctl[j-1];
        dd[j]  <= dd[j-1];
        pix[j] <= pix[j-1];
        for (int ch = 0; ch < 3; ch++) begin
          if (rem[j-1][ch] >= trial) begin
            rem[j][ch] <= rem[j-1][ch] - trial;
            q[j][ch]   <= q[j-1][ch] | (8'd1 << (8 - j));
          end else begin
            rem[j][ch] <= rem[j-1][ch];
            q[j][ch]   <= q[j-1][ch];
          end
        end
      end
    end
  end

  assign valid_out = v[8];
  assign pixel_out = (ctl[8].sel == SEL_MIX) ? {q[8][2], q[8][1], q[8][0]} : pix[8];
  assign seam_out  = ctl[8].is_seam;
  assign last_out  = ctl[8].last;

  a_mix_divisor: assert property (@(posedge clk) disable iff (rst)
    (v[0] && ctl[0].sel == SEL_MIX) |-> (dd[0] >= XW'(3)))
    else $error("mix with band under four columns");

  a_mix_offset: assert property (@(posedge clk) disable iff (rst)
    (valid_in && en && ctl_in.sel == SEL_MIX) |-> (x_in <= d_in))
    else $error("mix offset past band");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (v[8] && ctl[8].sel == SEL_MIX) |->
      (rem[8][0] < NW'(dd[8]) && rem[8][1] < NW'(dd[8]) && rem[8][2] < NW'(dd[8])))
    else $error("divider remainder not reduced");

endmodule
`default_nettype wire

// ===== hw/rtl/seam_blend_compositor_top.sv =====
// Top level of the seam blend compositor: registers, input stage with color
// correction, geometry pipeline and mix. Uses scb_pkg, scb_geom, scb_mix.
//
//  channel  | signals                                   | moves
//  input    | in_valid, in_ready, out_column, *_pixel   | one pixel item
//  output   | out_valid, out_ready, out_pixel, flags    | one stitched item
//  config   | write_enable, reg_index, write_data       | one register write
//
// One item per cycle unless the output stalls; stages: 4 geometry and correction, 1 sum, 8 divide.
// The geometry, sum and divider stages together set the depth; every stage moves together.
// A stalled output freezes the whole pipeline; in_ready drops in that cycle.
// Reset clears the valid bits and loads the register defaults.
`default_nettype none
module seam_blend_compositor_top
  import scb_pkg::*;
#(
  parameter int IMAGE_WIDTH = 640
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            write_enable,
  input  wire logic [2:0]      reg_index,
  input  wire logic [32:0]     write_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [10:0]     out_column,
  input  wire logic [PixW-1:0] left_pixel,
  input  wire logic [PixW-1:0] right_pixel,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [PixW-1:0]      out_pixel,
  output logic                 is_seam_column,
  output logic                 last_column
);
  localparam int XW = $clog2(IMAGE_WIDTH + 1);

  localparam logic [2:0] REG_GAINS   = 3'd0;
  localparam logic [2:0] REG_OFFSETS = 3'd1;
  localparam logic [2:0] REG_SHIFT   = 3'd2;
  localparam logic [2:0] REG_SEAM    = 3'd3;
  localparam logic [2:0] REG_BLEND   = 3'd4;

  logic [29:0] channel_gains;
  logic [32:0] channel_offsets;
  logic [10:0] shift_dx;
  logic [15:0] seam_pos;
  logic [9:0]  band_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_gains   <= 30'h10040100;
      channel_offsets <= '0;
      shift_dx        <= '0;
      seam_pos        <= 16'd32768;
      band_req        <= 10'd50;
    end else if (write_enable) begin
      case (reg_index)
        REG_GAINS:   channel_gains   <= write_data[29:0];
        REG_OFFSETS: channel_offsets <= write_data;
        REG_SHIFT:   shift_dx        <= write_data[10:0];
        REG_SEAM:    seam_pos        <= write_data[15:0];
        REG_BLEND:   band_req        <= write_data[9:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [PixW-1:0] rp_c;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rp_c[8*ch +: 8] = correct_chan(right_pixel[8*ch +: 8],
                                     channel_gains[GainW*ch +: GainW],
                                     channel_offsets[OffsetW*ch +: OffsetW]);
    end
  end

  logic [3:0]      v;
  logic [PixW-1:0] lp [0:3];
  logic [PixW-1:0] rp [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lp[0] <= left_pixel;
      rp[0] <= rp_c;
      for (int k = 1; k < 4; k++) begin
        lp[k] <= lp[k-1];
        rp[k] <= rp[k-1];
      end
    end
  end

  ctl_t          gctl;
  logic [XW-1:0] gx, gd;

  scb_geom #(.IMAGE_WIDTH(IMAGE_WIDTH), .XW(XW)) u_geom (
    .clk        (clk),
    .en         (en),
    .column     (out_column),
    .shift_dx   (shift_dx),
    .seam_pos   (seam_pos),
    .band_req   (band_req),
    .ctl        (gctl),
    .x          (gx),
    .d          (gd)
  );

  scb_mix #(.IMAGE_WIDTH(IMAGE_WIDTH), .XW(XW)) u_mix (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (v[3]),
    .ctl_in   (gctl),
    .x_in     (gx),
    .d_in     (gd),
    .lp_in    (lp[3]),
    .rp_in    (rp[3]),
    .valid_out(out_valid),
    .pixel_out(out_pixel),
    .seam_out (is_seam_column),
    .last_out (last_column)
  );

endmodule
`default_nettype wire
